FILE: rtl/tds_pkg.sv
// shared types, constants and helpers of the tridiagonal solver
package tds_pkg;

    localparam int MAX_ROWS_DEFAULT = 64;
    localparam int DATA_W           = 32;
    localparam int ROW_W            = 6;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_V0,
        OP_DIV_G,
        OP_CAP_G,
        OP_MUL_AG,
        OP_PIVOT,
        OP_MUL_AV,
        OP_NUM,
        OP_DIV_V,
        OP_STORE,
        OP_BS_INIT,
        OP_BS_RD,
        OP_BS_MUL,
        OP_BS_WR,
        OP_OUT_INIT
    } tds_op_t;

    typedef enum logic [1:0] {
        OOP_NONE,
        OOP_RD,
        OOP_LD,
        OOP_NEXT
    } tds_oop_t;

    typedef struct packed {
        tds_op_t  op;
        tds_oop_t oop;
        logic     clear;
    } tds_cmd_t;

    typedef struct packed {
        logic div_done;
        logic full;
        logic row0;
        logic last;
        logic j_zero;
        logic out_fire;
        logic out_last;
    } tds_status_t;

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] x,
                                                   input logic signed [47:0] m);
        logic signed [49:0] s;
        s = 50'(x) - 50'(m);
        if (s > 50'sd2147483647)
            return Q_MAX;
        else if (s < -50'sd2147483648)
            return Q_MIN;
        else
            return s[31:0];
    endfunction

endpackage

FILE: rtl/tds_div.sv
// radix-2 restoring divider for saturated q16.16 quotients
module tds_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num,
    input  logic signed [31:0]  den,
    output logic                done,
    output logic signed [31:0]  quo,
    output logic                zero
);

    localparam logic signed [31:0] Q_MAX_L = tds_pkg::Q_MAX;
    localparam logic signed [31:0] Q_MIN_L = tds_pkg::Q_MIN;

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic               zero_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        rem_next;
    logic [47:0]        q_reg;
    logic [47:0]        q_next;
    logic [31:0]        d_reg;
    logic signed [31:0] quo_reg;
    logic [32:0]        sh;
    logic               ge;
    logic [31:0]        num_abs;
    logic [31:0]        den_abs;

    assign num_abs = num[31] ? 32'(-num) : 32'(num);
    assign den_abs = den[31] ? 32'(-den) : 32'(den);

    always_comb
    begin
        sh       = {rem_reg, q_reg[47]};
        ge       = sh >= {1'b0, d_reg};
        rem_next = ge ? 32'(sh - {1'b0, d_reg}) : sh[31:0];
        q_next   = {q_reg[46:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            d_reg    <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                neg_reg  <= num[31] ^ den[31];
                d_reg    <= den_abs;
                q_reg    <= {num_abs, 16'h0000};
                rem_reg  <= '0;
                cnt_reg  <= '0;
                done_reg <= (den == 32'sd0);
                if (den == 32'sd0)
                begin
                    zero_reg <= 1'b1;
                    busy_reg <= 1'b0;
                    if (num > 32'sd0)
                        quo_reg <= Q_MAX_L;
                    else if (num < 32'sd0)
                        quo_reg <= Q_MIN_L;
                    else
                        quo_reg <= '0;
                end
                else
                begin
                    zero_reg <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                done_reg <= 1'b0;
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                cnt_reg  <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
                if (neg_reg)
                    quo_reg <= (q_reg > 48'h0000_8000_0000) ? Q_MIN_L : 32'(-q_reg[31:0]);
                else
                    quo_reg <= (q_reg > 48'h0000_7fff_ffff) ? Q_MAX_L : q_reg[31:0];
            end
            else
                done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign zero = zero_reg;

endmodule

FILE: rtl/tds_datapath.sv
// datapath: row registers, multiplier, stores, divider and output register
module tds_datapath #(
    parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tds_pkg::tds_cmd_t    cmd,
    output tds_pkg::tds_status_t status,
    input  logic signed [31:0]   sub_diag,
    input  logic signed [31:0]   main_diag,
    input  logic signed [31:0]   super_diag,
    input  logic signed [31:0]   rhs,
    input  logic                 last_row,
    output logic signed [31:0]   solution_value,
    output logic [5:0]           row_number,
    output logic                 last_result,
    output logic                 singular,
    output logic                 out_valid,
    input  logic                 out_ready
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    logic signed [31:0] ratio_mem [MAX_ROWS];
    logic signed [31:0] psol_mem  [MAX_ROWS];

    logic signed [31:0] a_reg, b_reg, c_reg, d_reg;
    logic               last_reg;
    logic signed [31:0] pivot_reg, prev_super_reg, prev_v_reg, g_reg, num_reg, cur_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] rd_ratio_reg, rd_psol_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      j_reg;
    logic               zero_seen_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_value_reg;
    logic [5:0]         out_row_reg;
    logic               out_last_reg;
    logic               out_sing_reg;

    logic               div_start;
    logic signed [31:0] div_num, div_den, div_quo;
    logic               div_done, div_zero;
    logic signed [47:0] mul48;
    logic [CW-1:0]      j_m1;
    logic               j_is_last;

    assign mul48     = prod_reg[63:16];
    assign j_m1      = j_reg - CW'(1);
    assign j_is_last = ({1'b0, j_reg} + (CW + 1)'(1)) == {1'b0, cnt_reg};

    always_comb
    begin
        div_start = 1'b0;
        div_num   = num_reg;
        div_den   = pivot_reg;
        unique case (cmd.op)
            tds_pkg::OP_DIV_V0:
            begin
                div_start = 1'b1;
                div_num   = d_reg;
                div_den   = b_reg;
            end
            tds_pkg::OP_DIV_G:
            begin
                div_start = 1'b1;
                div_num   = prev_super_reg;
            end
            tds_pkg::OP_DIV_V:
                div_start = 1'b1;
            default:
                div_start = 1'b0;
        endcase
    end

    tds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .zero  (div_zero)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == tds_pkg::OP_STORE)
        begin
            ratio_mem[cnt_reg[AW-1:0]] <= g_reg;
            psol_mem[cnt_reg[AW-1:0]]  <= div_quo;
        end
        if (cmd.op == tds_pkg::OP_BS_WR)
            psol_mem[j_m1[AW-1:0]] <= tds_pkg::sat_sub(rd_psol_reg, mul48);
        if (cmd.op == tds_pkg::OP_BS_RD)
        begin
            rd_ratio_reg <= ratio_mem[j_reg[AW-1:0]];
            rd_psol_reg  <= psol_mem[j_m1[AW-1:0]];
        end
        if (cmd.oop == tds_pkg::OOP_RD)
            rd_psol_reg <= psol_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tds_pkg::OP_LOAD:
            begin
                a_reg    <= sub_diag;
                b_reg    <= main_diag;
                c_reg    <= super_diag;
                d_reg    <= rhs;
                last_reg <= last_row;
            end
            tds_pkg::OP_CAP_G:  g_reg    <= div_quo;
            tds_pkg::OP_DIV_V0: g_reg    <= '0;
            tds_pkg::OP_MUL_AG: prod_reg <= a_reg * g_reg;
            tds_pkg::OP_MUL_AV: prod_reg <= a_reg * prev_v_reg;
            tds_pkg::OP_NUM:    num_reg  <= tds_pkg::sat_sub(d_reg, mul48);
            tds_pkg::OP_BS_MUL: prod_reg <= rd_ratio_reg * cur_reg;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg      <= '0;
            prev_super_reg <= '0;
            prev_v_reg     <= '0;
            cur_reg        <= '0;
            cnt_reg        <= '0;
            j_reg          <= '0;
            zero_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_row_reg    <= '0;
            out_last_reg   <= 1'b0;
            out_sing_reg   <= 1'b0;
        end
        else
        begin
            if (div_done && div_zero)
                zero_seen_reg <= 1'b1;
            unique case (cmd.op)
                tds_pkg::OP_DIV_V0:   pivot_reg <= b_reg;
                tds_pkg::OP_PIVOT:    pivot_reg <= tds_pkg::sat_sub(b_reg, mul48);
                tds_pkg::OP_STORE:
                begin
                    prev_v_reg     <= div_quo;
                    prev_super_reg <= c_reg;
                    cnt_reg        <= cnt_reg + CW'(1);
                end
                tds_pkg::OP_BS_INIT:
                begin
                    j_reg   <= cnt_reg - CW'(1);
                    cur_reg <= prev_v_reg;
                end
                tds_pkg::OP_BS_WR:
                begin
                    cur_reg <= tds_pkg::sat_sub(rd_psol_reg, mul48);
                    j_reg   <= j_m1;
                end
                tds_pkg::OP_OUT_INIT: j_reg <= '0;
                default:     ;
            endcase
            unique case (cmd.oop)
                tds_pkg::OOP_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_value_reg <= rd_psol_reg;
                    out_row_reg   <= 6'(j_reg);
                    out_last_reg  <= j_is_last;
                    out_sing_reg  <= zero_seen_reg;
                end
                tds_pkg::OOP_NEXT:
                    j_reg <= j_reg + CW'(1);
                default: ;
            endcase
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.clear)
            begin
                cnt_reg        <= '0;
                pivot_reg      <= '0;
                prev_super_reg <= '0;
                zero_seen_reg  <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.div_done = div_done;
        status.full     = cnt_reg == CW'(MAX_ROWS);
        status.row0     = cnt_reg == '0;
        status.last     = last_reg;
        status.j_zero   = j_reg == '0;
        status.out_fire = out_valid_reg && out_ready;
        status.out_last = out_last_reg;
    end

    assign solution_value = out_value_reg;
    assign row_number     = out_row_reg;
    assign last_result    = out_last_reg;
    assign singular       = out_sing_reg;
    assign out_valid      = out_valid_reg;

endmodule

FILE: rtl/tds_ctrl.sv
// controller state machine sequencing elimination and back substitution
module tds_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tds_pkg::tds_status_t status,
    output tds_pkg::tds_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_WAIT_G, S_MUL_AG, S_PIV, S_MUL_AV, S_NUM, S_DIV_V,
        S_WAIT_V, S_BS_INIT, S_BS_CHK, S_BS_RD, S_BS_MUL, S_BS_WR,
        S_OUT_RD, S_OUT_LD, S_OUT_WAIT, S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = tds_pkg::OP_NONE;
        cmd.oop    = tds_pkg::OOP_NONE;
        cmd.clear  = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = tds_pkg::OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (status.full)
                    state_next = status.last ? S_BS_INIT : S_IDLE;
                else if (status.row0)
                begin
                    cmd.op     = tds_pkg::OP_DIV_V0;
                    state_next = S_WAIT_V;
                end
                else
                begin
                    cmd.op     = tds_pkg::OP_DIV_G;
                    state_next = S_WAIT_G;
                end
            end
            S_WAIT_G:
                if (status.div_done)
                begin
                    cmd.op     = tds_pkg::OP_CAP_G;
                    state_next = S_MUL_AG;
                end
            S_MUL_AG:
            begin
                cmd.op     = tds_pkg::OP_MUL_AG;
                state_next = S_PIV;
            end
            S_PIV:
            begin
                cmd.op     = tds_pkg::OP_PIVOT;
                state_next = S_MUL_AV;
            end
            S_MUL_AV:
            begin
                cmd.op     = tds_pkg::OP_MUL_AV;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.op     = tds_pkg::OP_NUM;
                state_next = S_DIV_V;
            end
            S_DIV_V:
            begin
                cmd.op     = tds_pkg::OP_DIV_V;
                state_next = S_WAIT_V;
            end
            S_WAIT_V:
                if (status.div_done)
                begin
                    cmd.op     = tds_pkg::OP_STORE;
                    state_next = status.last ? S_BS_INIT : S_IDLE;
                end
            S_BS_INIT:
            begin
                cmd.op     = tds_pkg::OP_BS_INIT;
                state_next = S_BS_CHK;
            end
            S_BS_CHK:
                if (status.j_zero)
                begin
                    cmd.op     = tds_pkg::OP_OUT_INIT;
                    state_next = S_OUT_RD;
                end
                else
                    state_next = S_BS_RD;
            S_BS_RD:
            begin
                cmd.op     = tds_pkg::OP_BS_RD;
                state_next = S_BS_MUL;
            end
            S_BS_MUL:
            begin
                cmd.op     = tds_pkg::OP_BS_MUL;
                state_next = S_BS_WR;
            end
            S_BS_WR:
            begin
                cmd.op     = tds_pkg::OP_BS_WR;
                state_next = S_BS_CHK;
            end
            S_OUT_RD:
            begin
                cmd.oop    = tds_pkg::OOP_RD;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.oop    = tds_pkg::OOP_LD;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT:
                if (status.out_fire)
                begin
                    if (status.out_last)
                        state_next = S_CLEAR;
                    else
                    begin
                        cmd.oop    = tds_pkg::OOP_NEXT;
                        state_next = S_OUT_RD;
                    end
                end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/tridiagonal_system_solver_top.sv
// each row other than row 0 needs two 48-step divisions; row 0 needs one
// one row at a time: the shared divider serves both divisions of a row, and a new row is taken only in idle
// back substitution per row: check, read, multiply, write; output per element: read, load, wait out any stall
// reset clears the controller, counters, pivot, previous super-diagonal and singular flag
// the ratio and partial solution stores are not cleared
module tridiagonal_system_solver_top #(
    parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sub_diag,
    input  logic signed [31:0] main_diag,
    input  logic signed [31:0] super_diag,
    input  logic signed [31:0] rhs,
    input  logic               last_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] solution_value,
    output logic [5:0]         row_number,
    output logic               last_result,
    output logic               singular
);

    tds_pkg::tds_cmd_t    cmd;
    tds_pkg::tds_status_t status;

    tds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tds_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sub_diag       (sub_diag),
        .main_diag      (main_diag),
        .super_diag     (super_diag),
        .rhs            (rhs),
        .last_row       (last_row),
        .solution_value (solution_value),
        .row_number     (row_number),
        .last_result    (last_result),
        .singular       (singular),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

endmodule

FILE: rtl/tds_checker.sv
// port-level checker for the tridiagonal solver and its bind
module tds_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] solution_value,
    input logic [5:0]         row_number,
    input logic               last_result,
    input logic               singular
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(solution_value)
            && $stable(row_number))
        else $error("output transaction changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a solution is pending");

    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> !in_ready)
        else $error("input opened before the run finished");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_result |=> !out_valid)
        else $error("solution emitted after the last element");

endmodule

bind tridiagonal_system_solver_top tds_checker u_chk (.*);
